// ===== rtl/core/lfid_pkg.sv =====
// Shared types and constants for the lowest-free identifier allocator.
// Used by lfid_prio, lfid_pool and lowest_free_id_allocator; depends on nothing.
package lfid_pkg;

    // Pool geometry.
    localparam int POOL_DEPTH = 64;
    localparam int ID_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int SIZE_W     = 7;
    localparam int STATUS_W   = 3;

    // Action codes carried on the input beat.
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RETURN  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_OUT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

    // One result beat, before packing onto the output bus.
    typedef struct packed {
        logic [CNT_W-1:0]    outstanding;
        logic [ID_W-1:0]     granted_id;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// ===== rtl/core/lfid_prio.sv =====
// Lowest-index priority pick over the vector of free, in-range identifiers.
// Depends on lfid_pkg for the pool depth and identifier width.
module lfid_prio (
    input  logic [lfid_pkg::POOL_DEPTH-1:0] i_free,
    output logic                            o_found,
    output logic [lfid_pkg::ID_W-1:0]       o_id
);

    // Scan from the top down so the lowest free index wins.
    always_comb begin
        o_found = 1'b0;
        o_id    = '0;
        for (int i = lfid_pkg::POOL_DEPTH - 1; i >= 0; i--) begin
            if (i_free[i]) begin
                o_found = 1'b1;
                o_id    = lfid_pkg::ID_W'(i);
            end
        end
    end

endmodule

// ===== rtl/core/lfid_pool.sv =====
// Allocation bitmap, outstanding counter and the per-beat decision logic.
// Depends on lfid_pkg and instantiates lfid_prio.
module lfid_pool (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lfid_pkg::SIZE_W-1:0]   i_pool_size,
    input  logic                          i_fire,
    input  logic                          i_action,
    input  logic [lfid_pkg::ID_W-1:0]     i_return_id,
    output lfid_pkg::t_result             o_result
);

    logic [lfid_pkg::POOL_DEPTH-1:0] r_map;
    logic [lfid_pkg::POOL_DEPTH-1:0] n_map;
    logic [lfid_pkg::CNT_W-1:0]      r_count;
    logic [lfid_pkg::CNT_W-1:0]      n_count;
    logic [lfid_pkg::SIZE_W-1:0]     eff_size;
    logic [lfid_pkg::POOL_DEPTH-1:0] in_range;
    logic [lfid_pkg::POOL_DEPTH-1:0] free_vec;
    logic                            pick_found;
    logic [lfid_pkg::ID_W-1:0]       pick_id;

    // Saturate the configured size to the physical depth.
    assign eff_size = (i_pool_size > lfid_pkg::SIZE_W'(lfid_pkg::POOL_DEPTH))
                    ? lfid_pkg::SIZE_W'(lfid_pkg::POOL_DEPTH) : i_pool_size;

    // An identifier is a candidate when it is below the size and not held.
    always_comb begin
        for (int i = 0; i < lfid_pkg::POOL_DEPTH; i++) begin
            in_range[i] = lfid_pkg::SIZE_W'(i) < eff_size;
        end
    end

    assign free_vec = ~r_map & in_range;

    lfid_prio u_prio (
        .i_free  (free_vec),
        .o_found (pick_found),
        .o_id    (pick_id)
    );

    // Decide the status and the next bitmap and count for this beat.
    always_comb begin
        n_map               = r_map;
        n_count             = r_count;
        o_result.status     = lfid_pkg::ST_OK;
        o_result.granted_id = '0;
        if (i_action == lfid_pkg::ACT_REQUEST) begin
            if (pick_found) begin
                n_map[pick_id]      = 1'b1;
                n_count             = r_count + lfid_pkg::CNT_W'(1);
                o_result.granted_id = pick_id;
            end else begin
                o_result.status = lfid_pkg::ST_EXHAUSTED;
            end
        end else begin
            if (r_count == '0) begin
                o_result.status = lfid_pkg::ST_NONE_OUT;
            end else if ({1'b0, i_return_id} >= eff_size) begin
                o_result.status = lfid_pkg::ST_RANGE;
            end else if (!r_map[i_return_id]) begin
                o_result.status = lfid_pkg::ST_NOT_ALLOC;
            end else begin
                n_map[i_return_id] = 1'b0;
                n_count            = r_count - lfid_pkg::CNT_W'(1);
            end
        end
        o_result.outstanding = n_count;
    end

    // Commit the state when the beat moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_map   <= n_map;
            r_count <= n_count;
        end
    end

    // The counter always matches the number of held identifiers.
    a_count_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_map) == 32'(r_count))
        else $error("outstanding count disagrees with the bitmap");

    // A granted identifier is marked as held on the next cycle.
    a_grant_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_action == lfid_pkg::ACT_REQUEST && pick_found)
        |=> r_map[$past(pick_id)])
        else $error("granted identifier not marked as held");

    // A grant never falls outside the configured size.
    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_action == lfid_pkg::ACT_REQUEST && pick_found)
        |-> ({1'b0, pick_id} < eff_size))
        else $error("grant outside the pool size");

endmodule

// ===== rtl/core/lowest_free_id_allocator.sv =====
// Lowest-free identifier allocator: top level with input and result registers.
// Depends on lfid_pkg and instantiates lfid_pool.
//
// Usage:
//   s_axis carries one command per beat: tuser is the action (0 request,
//   1 return) and tdata holds the identifier being returned.
//   m_axis carries exactly one result per command: status, the granted
//   identifier (zero unless a request succeeded) and the number of
//   identifiers held after the command.
//   The cfg channel writes pool_size; write it only while no command is in
//   flight. It is always ready.
// Timing:
//   A beat is captured in the input register and, when the result register is free
//   or draining, decided by the bitmap and the priority pick into the result
//   register. One command is taken every cycle while m_axis_tready is high;
//   the bitmap update and lowest-free pick are combinational between the
//   two registers.
// Reset and stalls:
//   Reset frees every identifier, clears the count and sets pool_size to 64.
//   When m_axis_tready is low the result holds, one more command waits in
//   the input register, and s_axis_tready then drops.
module lowest_free_id_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Command channel.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [5:0] return_id, [7:6] zero
    input  logic       s_axis_tuser,   // [0] action
    // Result channel.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [2:0] status, [8:3] granted_id, [15:9] outstanding
    // Configuration channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [lfid_pkg::SIZE_W-1:0] i_cfg_data
);

    logic                          r_in_valid;
    logic                          r_in_action;
    logic [lfid_pkg::ID_W-1:0]     r_in_id;
    logic                          r_out_valid;
    lfid_pkg::t_result             r_out;
    lfid_pkg::t_result             n_out;
    logic [lfid_pkg::SIZE_W-1:0]   r_pool_size;
    logic                          advance;

    // A held command moves on when the result register is free or draining.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= lfid_pkg::SIZE_W'(64);
        end else if (i_cfg_valid) begin
            r_pool_size <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_id     <= s_axis_tdata[lfid_pkg::ID_W-1:0];
        end
    end

    lfid_pool u_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_size (r_pool_size),
        .i_fire      (advance),
        .i_action    (r_in_action),
        .i_return_id (r_in_id),
        .o_result    (n_out)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// ===== test/lowest_free_id_allocator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lowest_free_id_allocator: directed table, then random phases.
// Depends on lfid_pkg and the allocator RTL; expected results come from an in-bench model.
module lowest_free_id_allocator_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 14;
    localparam int NUM_PHASES  = 10;

    typedef enum logic {ROW_CMD, ROW_SIZE} t_row_kind;

    // One line of the directed table: a command beat or a pool_size write.
    typedef struct {
        t_row_kind                   kind;
        logic                        act;
        logic [lfid_pkg::SIZE_W-1:0] value;
        bit                          typed;
        lfid_pkg::t_result           want;
    } t_stim_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata;   // [5:0] return_id, [7:6] zero
    logic                        s_axis_tuser;   // [0] action
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [15:0]                 m_axis_tdata;   // [2:0] status, [8:3] granted_id, [15:9] outstanding
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [lfid_pkg::SIZE_W-1:0] i_cfg_data;

    // Pool model state, mirrored from what the block should hold.
    logic [lfid_pkg::POOL_DEPTH-1:0] held_map;
    int                              held_cnt;
    logic [lfid_pkg::SIZE_W-1:0]     pool_size_now;

    lfid_pkg::t_result pending_results[$];
    t_stim_row         plan[$];
    int                fail_cnt;
    int                cycle_cnt;
    bit                calm;
    bit                start_hold;
    int                hold_left;

    int phase_size[NUM_PHASES]  = '{64, 1, 0, 127, 5, 65, 2, 33, -1, 64};
    int phase_req[NUM_PHASES]   = '{85, 50, 50, 70, 55, 40, 50, 60, 50, 20};
    int phase_items[NUM_PHASES] = '{100, 50, 30, 100, 70, 70, 50, 80, 80, 100};

    lowest_free_id_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Apply one command to the pool model and return the result it must produce.
    function automatic lfid_pkg::t_result pool_step(input logic act,
                                                    input logic [lfid_pkg::ID_W-1:0] rid);
        lfid_pkg::t_result r;
        int                lim;
        int                pick;
        lim  = (pool_size_now > lfid_pkg::POOL_DEPTH) ? lfid_pkg::POOL_DEPTH
                                                      : int'(pool_size_now);
        r    = '0;
        pick = -1;
        r.status = lfid_pkg::ST_OK;
        if (act == lfid_pkg::ACT_REQUEST) begin
            for (int i = 0; i < lim; i++) begin
                if (!held_map[i] && pick < 0) pick = i;
            end
            if (pick >= 0) begin
                held_map[pick] = 1'b1;
                held_cnt++;
                r.granted_id = lfid_pkg::ID_W'(pick);
            end else begin
                r.status = lfid_pkg::ST_EXHAUSTED;
            end
        end else if (held_cnt == 0) begin
            r.status = lfid_pkg::ST_NONE_OUT;
        end else if (int'(rid) >= lim) begin
            r.status = lfid_pkg::ST_RANGE;
        end else if (!held_map[rid]) begin
            r.status = lfid_pkg::ST_NOT_ALLOC;
        end else begin
            held_map[rid] = 1'b0;
            held_cnt--;
        end
        r.outstanding = lfid_pkg::CNT_W'(held_cnt);
        return r;
    endfunction

    // Any identifier currently held, scanned from a random start; random if none is held.
    function automatic logic [lfid_pkg::ID_W-1:0] pick_held_id();
        int start;
        start = $urandom_range(lfid_pkg::POOL_DEPTH - 1);
        for (int k = 0; k < lfid_pkg::POOL_DEPTH; k++) begin
            if (held_map[(start + k) % lfid_pkg::POOL_DEPTH])
                return lfid_pkg::ID_W'((start + k) % lfid_pkg::POOL_DEPTH);
        end
        return lfid_pkg::ID_W'(start);
    endfunction

    task automatic add_row(input t_row_kind kind, input logic act,
                           input logic [lfid_pkg::SIZE_W-1:0] value,
                           input bit typed, input logic [lfid_pkg::STATUS_W-1:0] st,
                           input logic [lfid_pkg::ID_W-1:0] gid,
                           input logic [lfid_pkg::CNT_W-1:0] cnt);
        t_stim_row row;
        row.kind             = kind;
        row.act              = act;
        row.value            = value;
        row.typed            = typed;
        row.want.status      = st;
        row.want.granted_id  = gid;
        row.want.outstanding = cnt;
        plan.push_back(row);
    endtask

    // Offer one command beat after a random gap; record its expected result on acceptance.
    task automatic send_cmd(input logic act, input logic [lfid_pkg::ID_W-1:0] rid,
                            input bit typed, input lfid_pkg::t_result want);
        lfid_pkg::t_result r;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, rid};
        do @(posedge i_clk); while (!s_axis_tready);
        r = pool_step(act, rid);
        pending_results.push_back(typed ? want : r);
    endtask

    // Let every outstanding result come back, then write pool_size while the block is idle.
    task automatic set_pool_size(input logic [lfid_pkg::SIZE_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        pool_size_now = v;
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (start_hold) begin
                start_hold = 1'b0;
                hold_left  = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare every result beat with the oldest expectation.
    always @(posedge i_clk) begin
        lfid_pkg::t_result got;
        lfid_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = lfid_pkg::t_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    fail_cnt++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.granted_id !== want.granted_id) begin
                    fail_cnt++;
                    $display("%0t: granted_id expected %0d actual %0d",
                             $time, want.granted_id, got.granted_id);
                end
                if (got.outstanding !== want.outstanding) begin
                    fail_cnt++;
                    $display("%0t: outstanding expected %0d actual %0d",
                             $time, want.outstanding, got.outstanding);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic                        act;
        logic [lfid_pkg::ID_W-1:0]   rid;
        logic [lfid_pkg::SIZE_W-1:0] sz;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lfid_pkg::ACT_REQUEST;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        held_map      = '0;
        held_cnt      = 0;
        pool_size_now = lfid_pkg::SIZE_W'(64);
        fail_cnt      = 0;
        cycle_cnt     = 0;
        calm          = 1'b0;
        start_hold    = 1'b0;
        hold_left     = 0;

        // Directed table: reset state, lowest-first reuse, shrinking, size zero, saturation.
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  0,   1, lfid_pkg::ST_NONE_OUT,  0, 0);
        add_row(ROW_CMD,  lfid_pkg::ACT_REQUEST, 0,   1, lfid_pkg::ST_OK,        0, 1);
        add_row(ROW_CMD,  lfid_pkg::ACT_REQUEST, 63,  1, lfid_pkg::ST_OK,        1, 2);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  63,  1, lfid_pkg::ST_NOT_ALLOC, 0, 2);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  0,   1, lfid_pkg::ST_OK,        0, 1);
        add_row(ROW_CMD,  lfid_pkg::ACT_REQUEST, 0,   1, lfid_pkg::ST_OK,        0, 2);
        add_row(ROW_SIZE, lfid_pkg::ACT_REQUEST, 2,   0, lfid_pkg::ST_OK,        0, 0);
        add_row(ROW_CMD,  lfid_pkg::ACT_REQUEST, 0,   1, lfid_pkg::ST_EXHAUSTED, 0, 2);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  2,   1, lfid_pkg::ST_RANGE,     0, 2);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  1,   1, lfid_pkg::ST_OK,        0, 1);
        add_row(ROW_CMD,  lfid_pkg::ACT_REQUEST, 0,   1, lfid_pkg::ST_OK,        1, 2);
        // IDs held above a shrunk size still count but cannot be returned.
        add_row(ROW_SIZE, lfid_pkg::ACT_REQUEST, 1,   0, lfid_pkg::ST_OK,        0, 0);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  1,   1, lfid_pkg::ST_RANGE,     0, 2);
        add_row(ROW_SIZE, lfid_pkg::ACT_REQUEST, 0,   0, lfid_pkg::ST_OK,        0, 0);
        add_row(ROW_CMD,  lfid_pkg::ACT_REQUEST, 0,   1, lfid_pkg::ST_EXHAUSTED, 0, 2);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  0,   1, lfid_pkg::ST_RANGE,     0, 2);
        // A size above the depth saturates to the full pool.
        add_row(ROW_SIZE, lfid_pkg::ACT_REQUEST, 127, 0, lfid_pkg::ST_OK,        0, 0);
        add_row(ROW_CMD,  lfid_pkg::ACT_REQUEST, 0,   0, lfid_pkg::ST_OK,        0, 0);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  42,  1, lfid_pkg::ST_NOT_ALLOC, 0, 3);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  21,  1, lfid_pkg::ST_NOT_ALLOC, 0, 3);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  0,   1, lfid_pkg::ST_OK,        0, 2);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  1,   1, lfid_pkg::ST_OK,        0, 1);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  2,   1, lfid_pkg::ST_OK,        0, 0);
        add_row(ROW_CMD,  lfid_pkg::ACT_RETURN,  5,   1, lfid_pkg::ST_NONE_OUT,  0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_SIZE)
                set_pool_size(plan[i].value);
            else
                send_cmd(plan[i].act, plan[i].value[lfid_pkg::ID_W-1:0], plan[i].typed,
                         plan[i].want);
        end

        // Random phases: most returns name a held ID, the rest any ID.
        for (int p = 0; p < NUM_PHASES; p++) begin
            sz = (phase_size[p] < 0)
               ? lfid_pkg::SIZE_W'($urandom_range(1, lfid_pkg::POOL_DEPTH))
               : lfid_pkg::SIZE_W'(phase_size[p]);
            set_pool_size(sz);
            calm = (p == 7);
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 3 && n == 20) start_hold = 1'b1;
                act = ($urandom_range(99) < phase_req[p]) ? lfid_pkg::ACT_REQUEST
                                                          : lfid_pkg::ACT_RETURN;
                rid = ($urandom_range(99) < 70)
                    ? pick_held_id()
                    : lfid_pkg::ID_W'($urandom_range(lfid_pkg::POOL_DEPTH - 1));
                send_cmd(act, rid, 1'b0, '0);
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lfid_pkg.sv
rtl/core/lfid_prio.sv
rtl/core/lfid_pool.sv
rtl/core/lowest_free_id_allocator.sv
test/lowest_free_id_allocator_tb.sv
